// File: rtl/hsba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsba_pkg
// Shared types and constants for the header seek byte aligner: the mode
// encoding, the architectural state record and the register map.
// ----------------------------------------------------------------------------
package hsba_pkg;

  // stream word, window, carry, header and count widths
  localparam int WordW   = 32;
  localparam int WindowW = 64;
  localparam int CarryW  = 24;
  localparam int HdrW    = 40;
  localparam int CountW  = 6;

  // configuration port
  localparam int PaddrW  = 4;
  localparam int PdataW  = 64;

  // register index, taken from paddr[3]
  localparam logic REG_HEADER_PATTERN = 1'b0;

  // escape word substitution
  localparam logic [WordW-1:0] ESC_WORD  = 32'h2323_2323;
  localparam logic [WordW-1:0] SUBST_WORD = 32'h2020_2020;

  // header frame length in bytes
  localparam logic [CountW-1:0] FRAME_BYTES = 6'd32;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_FOUND  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [WindowW-1:0] window;
    logic [CarryW-1:0]  carry_bytes;
    logic [1:0]         align_offset;
    logic [CountW-1:0]  byte_count;
    logic [1:0]         mode;
  } state_t;

endpackage

// File: rtl/header_seek_byte_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_seek_byte_aligner
// Stream word aligner: finds a five-byte header at a byte offset, moves it
// onto a word boundary and splices the following bytes for one frame.
//
//   channel  | direction | handshake             | payload
//   in       | input     | in_valid / in_stall   | in_word[31:0]
//   out      | output    | out_valid / out_stall | out_word[31:0]
//   config   | input     | APB psel/penable      | pwdata[39:0] at paddr 0
//
// One request is taken per cycle while in_stall is low; its result appears in
// the output register on the next cycle. The step logic between the state
// registers and the output register is combinational.
// rst is synchronous and active high; it clears state, mode and the pattern.
// in_stall is raised only while the output register holds an untaken result
// and out_stall is high.
// ----------------------------------------------------------------------------
module header_seek_byte_aligner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsba_pkg::WordW-1:0]    in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsba_pkg::WordW-1:0]    out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsba_pkg::PaddrW-1:0]   paddr,
  input  logic [hsba_pkg::PdataW-1:0]   pwdata,
  output logic [hsba_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import hsba_pkg::*;

  logic [HdrW-1:0] header_pattern;
  state_t          state;
  state_t          state_next;
  logic            in_accept;
  logic            cfg_write;
  logic            hit_reg;

  // configuration port
  assign pready    = 1'b1;
  assign hit_reg   = (paddr[3] == REG_HEADER_PATTERN);
  assign cfg_write = psel && penable && pwrite && pready && hit_reg;
  assign prdata    = hit_reg ? {{(PdataW-HdrW){1'b0}}, header_pattern} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= '0;
    end else if (cfg_write) begin
      header_pattern <= pwdata[HdrW-1:0];
    end
  end

  // handshake
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  hsba_step u_step (
    .cur            (state),
    .in_word        (in_word),
    .header_pattern (header_pattern),
    .nxt            (state_next)
  );

  // state registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        state    <= state_next;
        out_word <= state_next.window[WindowW-1:WordW];
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request did not produce a result");

  a_found_offset: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_FOUND) |-> (state.align_offset != 2'd0))
    else $error("found mode with zero alignment offset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_SEARCH || state.mode == MODE_FOUND) |-> !state.byte_count[5])
    else $error("byte count beyond frame while active");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (in_accept && state.mode == MODE_IDLE) |=> (state.byte_count == '0))
    else $error("idle step did not clear byte count");

endmodule

// File: rtl/hsba_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsba_step
// Next-state logic for one stream word: escape substitution, window shift,
// header compare at three byte offsets, alignment and carry splicing.
// ----------------------------------------------------------------------------
module hsba_step (
  input  hsba_pkg::state_t               cur,
  input  logic [hsba_pkg::WordW-1:0]     in_word,
  input  logic [hsba_pkg::HdrW-1:0]      header_pattern,
  output hsba_pkg::state_t               nxt
);
  import hsba_pkg::*;

  logic [WordW-1:0]   w;
  logic [WindowW-1:0] win;
  logic               m3;
  logic               m2;
  logic               m1;
  logic [CountW-1:0]  cnt_plus4;

  // escape substitution and window shift
  assign w   = (in_word == ESC_WORD) ? SUBST_WORD : in_word;
  assign win = {cur.window[WordW-1:0], w};

  // header compare at byte offsets 3, 2 and 1
  assign m3 = (win[55:16] == header_pattern);
  assign m2 = (win[47:8]  == header_pattern);
  assign m1 = (win[39:0]  == header_pattern);

  assign cnt_plus4 = cur.byte_count + CountW'(4);

  // mode dependent update
  always_comb begin
    nxt        = cur;
    nxt.window = win;
    case (cur.mode)
      MODE_SEARCH: begin
        if (m3) begin
          nxt.window       = {win[63:56], 24'd0, win[55:24]};
          nxt.carry_bytes  = win[23:0];
          nxt.byte_count   = cur.byte_count + CountW'(1);
          nxt.align_offset = 2'd3;
          nxt.mode         = MODE_FOUND;
        end else if (m2) begin
          nxt.window       = {win[63:48], 16'd0, win[47:16]};
          nxt.carry_bytes  = {cur.carry_bytes[23:16], win[15:0]};
          nxt.byte_count   = cur.byte_count + CountW'(2);
          nxt.align_offset = 2'd2;
          nxt.mode         = MODE_FOUND;
        end else if (m1) begin
          nxt.window       = {win[63:40], 8'd0, win[39:8]};
          nxt.carry_bytes  = {cur.carry_bytes[23:8], win[7:0]};
          nxt.byte_count   = cur.byte_count + CountW'(3);
          nxt.align_offset = 2'd1;
          nxt.mode         = MODE_FOUND;
        end else begin
          nxt.byte_count = cnt_plus4;
          if (cnt_plus4 >= FRAME_BYTES) begin
            nxt.mode = MODE_IDLE;
          end
        end
      end
      MODE_FOUND: begin
        nxt.byte_count = cnt_plus4;
        if (cnt_plus4 >= FRAME_BYTES) begin
          nxt.mode = MODE_IDLE;
        end else begin
          // splice held bytes ahead of the new word
          case (cur.align_offset)
            2'd3: begin
              nxt.window      = {win[63:32], cur.carry_bytes[23:0], w[31:24]};
              nxt.carry_bytes = w[23:0];
            end
            2'd2: begin
              nxt.window      = {win[63:32], cur.carry_bytes[15:0], w[31:16]};
              nxt.carry_bytes = {cur.carry_bytes[23:16], w[15:0]};
            end
            2'd1: begin
              nxt.window      = {win[63:32], cur.carry_bytes[7:0], w[31:8]};
              nxt.carry_bytes = {cur.carry_bytes[23:8], w[7:0]};
            end
            default: begin
              nxt.window = win;
            end
          endcase
        end
      end
      default: begin
        // idle, and the unused code
        nxt.byte_count   = '0;
        nxt.carry_bytes  = '0;
        nxt.align_offset = 2'd0;
        nxt.mode         = (w != '0) ? MODE_SEARCH : MODE_IDLE;
      end
    endcase
  end

endmodule

// File: test/header_seek_byte_aligner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_seek_byte_aligner_tb
// Self-checking bench for the header seek byte aligner. A short table of
// directed requests covers the escape word, headers at all three byte
// offsets and the ignored upper pattern bits. Random phases follow, each
// under its own header pattern, built mostly from well-formed header frames
// plus broken frames and noise. Every output word is checked against a
// cycle-free model or, for chk rows, the table. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module header_seek_byte_aligner_tb;
  import hsba_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 48;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DIR_N       = 24;
  localparam logic [PaddrW-1:0] HDR_ADDR = {REG_HEADER_PATTERN, 3'b000};

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] data;
    logic        chk;
    logic [31:0] expv;
  } row_t;

  // directed stimulus; expv is used only where chk is set
  row_t dir_rows [0:DIR_N-1] = '{
    // pattern "HEADR" with junk in the ignored upper bits
    '{ROW_CFG,  64'hFFFF_FF48_4541_4452, 1'b0, 32'h0},
    // escape word out of reset, then no match yet
    '{ROW_WORD, 64'h2323_2323, 1'b1, 32'h0000_0000},
    '{ROW_WORD, 64'h0048_4541, 1'b1, 32'h2020_2020},
    // header with three carry bytes, then splicing
    '{ROW_WORD, 64'h4452_BEEF, 1'b0, 32'h0},
    '{ROW_WORD, 64'hCAFE_F00D, 1'b0, 32'h0},
    '{ROW_WORD, 64'h2323_2323, 1'b0, 32'h0},
    '{ROW_WORD, 64'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, 64'h8000_0000, 1'b0, 32'h0},
    '{ROW_WORD, 64'h0000_0001, 1'b0, 32'h0},
    '{ROW_WORD, 64'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, 64'h0000_0000, 1'b0, 32'h0},
    // header with two carry bytes
    '{ROW_WORD, 64'h0000_4845, 1'b0, 32'h0},
    '{ROW_WORD, 64'h4144_52FF, 1'b0, 32'h0},
    '{ROW_WORD, 64'h5555_5555, 1'b0, 32'h0},
    '{ROW_WORD, 64'hAAAA_AAAA, 1'b0, 32'h0},
    '{ROW_WORD, 64'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, 64'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WORD, 64'h2323_2323, 1'b0, 32'h0},
    '{ROW_WORD, 64'h0102_0304, 1'b0, 32'h0},
    '{ROW_WORD, 64'hFEDC_BA98, 1'b0, 32'h0},
    '{ROW_WORD, 64'h0000_0000, 1'b0, 32'h0},
    // header with one carry byte
    '{ROW_WORD, 64'h1122_3348, 1'b0, 32'h0},
    '{ROW_WORD, 64'h4541_4452, 1'b0, 32'h0},
    '{ROW_WORD, 64'hDEAD_BEEF, 1'b0, 32'h0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WordW-1:0]  in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WordW-1:0]  out_word;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // aligner model state
  logic [HdrW-1:0]    hdr_pattern = '0;
  logic [WindowW-1:0] win = '0;
  logic [CarryW-1:0]  carry = '0;
  logic [1:0]         ofs = '0;
  logic [CountW-1:0]  cnt = '0;
  mode_t              align_mode = MODE_IDLE;

  logic [WordW-1:0] aligned_due[$];
  logic [WordW-1:0] due_word;
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  // idling controls, written by the stimulus process with nonblocking updates
  int busy_pct = 15;
  bit hold_req = 1'b0;

  // receiver-side state, owned by the stall process
  bit hold_done = 1'b0;
  int hold_count = 0;
  int stall_left = 0;
  logic stall_next;

  header_seek_byte_aligner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one step of the aligner: returns the word it puts out
  function automatic logic [WordW-1:0] align_step(input logic [WordW-1:0] raw);
    logic [WordW-1:0] w;
    int k;
    logic [31:0] kmask;
    logic [31:0] low;
    logic [63:0] clr;
    logic [31:0] lw;
    logic [31:0] old;
    w = (raw == ESC_WORD) ? SUBST_WORD : raw;
    win = {win[31:0], w};
    case (align_mode)
      MODE_SEARCH: begin
        k = 0;
        if (win[55:16] == hdr_pattern) k = 3;
        else if (win[47:8] == hdr_pattern) k = 2;
        else if (win[39:0] == hdr_pattern) k = 1;
        if (k != 0) begin
          // move header onto the word boundary, keep k bytes as carry
          kmask = (32'd1 << (8 * k)) - 32'd1;
          low = 32'(win >> (8 * k));
          clr = ((64'd1 << (8 * k + 32)) - 64'd1) & ~64'hFFFF_FFFF;
          carry = (carry & ~kmask[23:0]) | (win[23:0] & kmask[23:0]);
          win = (win & ~clr & ~64'hFFFF_FFFF) | {32'd0, low};
          cnt = cnt + CountW'(4 - k);
          ofs = 2'(k);
          align_mode = MODE_FOUND;
        end else begin
          cnt = cnt + 6'd4;
          if (cnt >= FRAME_BYTES) align_mode = MODE_IDLE;
        end
      end
      MODE_FOUND: begin
        cnt = cnt + 6'd4;
        if (cnt >= FRAME_BYTES) begin
          align_mode = MODE_IDLE;
        end else if (ofs != 2'd0) begin
          // splice held bytes ahead of the new word
          k = int'(ofs);
          kmask = (32'd1 << (8 * k)) - 32'd1;
          lw = win[31:0];
          old = {8'd0, carry} & kmask;
          carry = (carry & ~kmask[23:0]) | (lw[23:0] & kmask[23:0]);
          win[31:0] = (lw >> (8 * k)) | (old << (32 - 8 * k));
        end
      end
      default: begin
        cnt = '0;
        carry = '0;
        ofs = '0;
        align_mode = (w != '0) ? MODE_SEARCH : MODE_IDLE;
      end
    endcase
    return win[63:32];
  endfunction

  // offer one request, wait for it to be taken, then log its output word
  task automatic push_word(input logic [WordW-1:0] w, input logic typed,
                           input logic [WordW-1:0] typed_exp);
    logic [WordW-1:0] predicted;
    if (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = align_step(w);
    aligned_due.push_back(typed ? typed_exp : predicted);
    items_sent++;
  endtask

  // stop offering and wait for every output word to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (aligned_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_header(input logic [PdataW-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HDR_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hdr_pattern = v[HdrW-1:0];
  endtask

  // random bytes, a header (possibly damaged) and a pad to the word boundary
  task automatic send_frame(input bit broken);
    logic [7:0] bq[$];
    logic [7:0] hdr[5];
    logic [WordW-1:0] w;
    int lead;
    // let a frame in progress run to its end with random content
    while (align_mode == MODE_FOUND) push_word($urandom, 1'b0, '0);
    for (int i = 0; i < 5; i++) hdr[i] = hdr_pattern[39 - 8 * i -: 8];
    if (broken) begin
      lead = $urandom_range(0, 4);
      hdr[lead] = hdr[lead] ^ 8'(1 << $urandom_range(0, 7));
    end
    lead = $urandom_range(1, 7);
    for (int i = 0; i < lead; i++) bq.push_back(8'($urandom_range(1, 255)));
    for (int i = 0; i < 5; i++) bq.push_back(hdr[i]);
    while (bq.size() % 4 != 0) bq.push_back(8'($urandom));
    while (bq.size() != 0) begin
      for (int j = 0; j < 4; j++) w = {w[23:0], bq.pop_front()};
      push_word(w, 1'b0, '0);
    end
  endtask

  // a few loose words: random, zero, escape or all ones
  task automatic send_noise();
    logic [WordW-1:0] w;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0:       w = $urandom;
        1:       w = '0;
        2:       w = ESC_WORD;
        default: w = '1;
      endcase
      push_word(w, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    int busy_tab [PHASES] = '{20, 0, 30, 10, 40, 0};
    int phase_end;
    int pick;
    bit held;
    bit paused;
    logic [PdataW-1:0] pw;
    held = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].kind == ROW_CFG) write_header(dir_rows[i].data);
      else push_word(dir_rows[i].data[WordW-1:0], dir_rows[i].chk, dir_rows[i].expv);
    end

    // random phases, each under its own pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       pw = '0;
        1:       pw = '1;
        default: pw = {$urandom, $urandom};
      endcase
      write_header(pw);
      busy_pct <= busy_tab[ph];
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (ph == 2 && !held && items_sent + 130 >= phase_end) begin
          // receiver holds off while requests keep coming
          hold_req <= 1'b1;
          held = 1'b1;
        end
        if (ph == 3 && !paused && items_sent + 100 >= phase_end) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) send_frame(1'b0);
        else if (pick < 85) send_frame(1'b1);
        else send_noise();
      end
    end

    drain();
    repeat (3) @(posedge clk);
    if (errors == 0 && aligned_due.size() == 0) begin
      $display("** header_seek_byte_aligner: PASSED **");
    end else begin
      $display("** header_seek_byte_aligner: FAILED **");
    end
    $finish;
  end

  // receiver stall: random bursts plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      stall_next = 1'b0;
    end else if (hold_req && !hold_done) begin
      stall_next = 1'b1;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (stall_left != 0) begin
      stall_next = 1'b1;
      stall_left--;
    end else if (busy_pct != 0 && $urandom_range(0, 99) < busy_pct) begin
      stall_next = 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      stall_next = 1'b0;
    end
    out_stall <= stall_next;
  end

  // compare each taken output word with the oldest expected one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (aligned_due.size() == 0) begin
        $error("out_word: unexpected result, actual %h", out_word);
        errors++;
      end else begin
        due_word = aligned_due.pop_front();
        if (out_word !== due_word) begin
          $error("out_word: expected %h, actual %h", due_word, out_word);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** header_seek_byte_aligner: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
